FILE: src/pressure_smoothing_climb_estimator_defines.svh
// Assertion macros shared by the pressure smoothing climb estimator.
`ifndef PRESSURE_SMOOTHING_CLIMB_ESTIMATOR_DEFINES_SVH
`define PRESSURE_SMOOTHING_CLIMB_ESTIMATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define PSCE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define PSCE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/psce_pkg.sv
// Types and constants shared by the pressure smoothing climb estimator.
package psce_pkg;

    // Field widths.
    localparam int SAMPLE_W   = 17;
    localparam int ENTRY_W    = 16;
    localparam int CLIMB_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    // Blend sum 7*a + 3*b of two samples needs four more bits.
    localparam int BLEND_W = SAMPLE_W + 4;

    // floor(x / 10) = (x * ceil(2^24 / 10)) >> 24, exact for x below 2^22.
    localparam int RECIP_W     = 21;
    localparam int RECIP_SHIFT = 24;
    localparam logic [RECIP_W-1:0] RECIP_TEN = 21'd1677722;

    typedef logic [SAMPLE_W-1:0]          t_pressure;
    typedef logic signed [ENTRY_W-1:0]    t_entry;
    typedef logic signed [CLIMB_W-1:0]    t_climb;
    typedef logic [CFG_IDX_W-1:0]         t_cfg_index;
    typedef logic [CFG_DATA_W-1:0]        t_cfg_data;

    // Configuration register indexes.
    localparam t_cfg_index CFG_FILTER_ENABLE   = 2'd0;
    localparam t_cfg_index CFG_BASELINE        = 2'd1;

    // Saturation limits of a ring entry.
    localparam t_entry ENTRY_MAX = 16'sh7FFF;
    localparam t_entry ENTRY_MIN = 16'sh8000;

endpackage

FILE: src/psce_sample_if.sv
// Input channel carrying one raw pressure item.
interface psce_sample_if;
    logic                 valid;
    logic                 ready;
    psce_pkg::t_pressure  pressure_sample;

    modport source (output valid, output pressure_sample, input ready);
    modport sink   (input valid, input pressure_sample, output ready);
endinterface

FILE: src/psce_result_if.sv
// Output channel carrying one smoothed pressure and climb item.
interface psce_result_if;
    logic                 valid;
    logic                 ready;
    psce_pkg::t_pressure  smoothed_pressure;
    psce_pkg::t_climb     climb_value;

    modport source (output valid, output smoothed_pressure, output climb_value, input ready);
    modport sink   (input valid, input smoothed_pressure, input climb_value, output ready);
endinterface

FILE: src/psce_smooth.sv
// Optional 0.7/0.3 blend of a sample with the previous smoothed pressure.
module psce_smooth (
    input  psce_pkg::t_pressure i_sample,
    input  psce_pkg::t_pressure i_prev,
    input  logic                i_filter_en,
    output psce_pkg::t_pressure o_pressure
);
    import psce_pkg::*;

    localparam int PROD_W = BLEND_W + RECIP_W;

    logic [BLEND_W-1:0] sample_x7;
    logic [BLEND_W-1:0] prev_x3;
    logic [BLEND_W-1:0] blend_sum;
    logic [PROD_W-1:0]  blend_prod;
    logic               use_blend;

    // Weighted sum 7*sample + 3*previous from shifts and adds.
    assign sample_x7 = (BLEND_W'(i_sample) << 3) - BLEND_W'(i_sample);
    assign prev_x3   = (BLEND_W'(i_prev) << 1) + BLEND_W'(i_prev);
    assign blend_sum = sample_x7 + prev_x3;

    // Divide by ten through the reciprocal multiply.
    assign blend_prod = PROD_W'(blend_sum) * PROD_W'(RECIP_TEN);

    // A zero previous value means no history yet, so the sample passes.
    assign use_blend  = i_filter_en && (i_prev != '0);
    assign o_pressure = use_blend ? blend_prod[RECIP_SHIFT +: SAMPLE_W] : i_sample;

endmodule

FILE: src/psce_climb.sv
// History shift line of baseline differences and the running climb sum.
module psce_climb #(
    parameter int HISTORY_DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_shift,
    input  psce_pkg::t_pressure i_pressure,
    input  psce_pkg::t_pressure i_baseline,
    output psce_pkg::t_climb    o_climb
);
    import psce_pkg::*;

    // Tap 0 holds the newest entry. The oldest tap is the entry leaving the
    // window; the half tap is the entry written half a window ago.
    localparam int OLD_TAP  = HISTORY_DEPTH - 1;
    localparam int HALF_TAP = HISTORY_DEPTH - HISTORY_DEPTH / 2 - 1;
    localparam int EXT_W    = CLIMB_W - ENTRY_W;

    t_entry                r_ring [HISTORY_DEPTH];
    t_climb                r_climb;
    t_climb                n_climb;
    logic signed [SAMPLE_W:0] diff;
    logic [SAMPLE_W-ENTRY_W+1:0] diff_top;
    t_entry                entry;
    t_entry                old_entry;
    t_entry                half_entry;
    t_climb                old_ext;
    t_climb                new_ext;
    t_climb                half_ext;

    // Difference from baseline, saturated to the entry range.
    assign diff     = $signed({1'b0, i_pressure}) - $signed({1'b0, i_baseline});
    assign diff_top = diff[SAMPLE_W:ENTRY_W-1];

    always_comb begin
        if ((&diff_top) || !(|diff_top)) begin
            entry = diff[ENTRY_W-1:0];
        end else if (diff[SAMPLE_W]) begin
            entry = ENTRY_MIN;
        end else begin
            entry = ENTRY_MAX;
        end
    end

    // Sign-extended terms of the sum update.
    assign old_entry  = r_ring[OLD_TAP];
    assign half_entry = r_ring[HALF_TAP];
    assign old_ext    = {{EXT_W{old_entry[ENTRY_W-1]}}, old_entry};
    assign new_ext    = {{EXT_W{entry[ENTRY_W-1]}}, entry};
    assign half_ext   = {{EXT_W{half_entry[ENTRY_W-1]}}, half_entry};

    assign n_climb = r_climb + old_ext + new_ext - (half_ext <<< 1);

    // The line shifts and the sum updates once per item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_climb <= '0;
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
                r_ring[i] <= '0;
            end
        end else if (i_shift) begin
            r_climb   <= n_climb;
            r_ring[0] <= entry;
            for (int i = 1; i < HISTORY_DEPTH; i++) begin
                r_ring[i] <= r_ring[i-1];
            end
        end
    end

    assign o_climb = r_climb;

endmodule

FILE: src/pressure_smoothing_climb_estimator.sv
// Top level of the pressure smoothing climb estimator.
// An accepted item passes the input register, the smoothing register and
// the result register. Throughput: one item per cycle while results are taken;
// the previous-value loop closes through the blend multiplier, the climb sum
// through one wide add. Reset (synchronous, active low) clears the valid flags,
// the configuration, the previous value, the history line and the climb sum.
`include "pressure_smoothing_climb_estimator_defines.svh"

module pressure_smoothing_climb_estimator #(
    parameter int HISTORY_DEPTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  psce_pkg::t_cfg_index  i_cfg_index,
    input  psce_pkg::t_cfg_data   i_cfg_data,
    psce_sample_if.sink           i_sample_ch,
    psce_result_if.source         o_result_ch
);
    import psce_pkg::*;

    logic      r_filter_en;
    t_pressure r_baseline;

    logic      r_s1_valid;
    t_pressure r_s1_sample;
    logic      r_s2_valid;
    t_pressure r_prev;
    logic      r_out_valid;
    t_pressure r_out_pressure;

    t_pressure n_prev;
    t_climb    climb;
    logic      out_free;
    logic      s2_free;
    logic      s1_free;
    logic      s1_move;
    logic      s2_move;
    logic      in_take;

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_en <= 1'b0;
            r_baseline  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FILTER_ENABLE: r_filter_en <= i_cfg_data[0];
                CFG_BASELINE:      r_baseline  <= i_cfg_data[SAMPLE_W-1:0];
                default: ;
            endcase
        end
    end

    // Each stage loads when empty or when its contents move on.
    assign out_free = !r_out_valid || o_result_ch.ready;
    assign s2_free  = !r_s2_valid || out_free;
    assign s1_free  = !r_s1_valid || s2_free;
    assign s2_move  = r_s2_valid && out_free;
    assign s1_move  = r_s1_valid && s2_free;
    assign in_take  = i_sample_ch.valid && s1_free;

    assign i_sample_ch.ready = s1_free;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_free) begin
            r_s1_valid <= i_sample_ch.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_sample <= i_sample_ch.pressure_sample;
        end
    end

    // Smoothing stage; its result doubles as the previous value.
    psce_smooth u_smooth (
        .i_sample    (r_s1_sample),
        .i_prev      (r_prev),
        .i_filter_en (r_filter_en),
        .o_pressure  (n_prev)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_prev     <= '0;
        end else begin
            if (s2_free) begin
                r_s2_valid <= r_s1_valid;
            end
            if (s1_move) begin
                r_prev <= n_prev;
            end
        end
    end

    // Climb window, updated as an item enters the result register.
    psce_climb #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_climb (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_shift    (s2_move),
        .i_pressure (r_prev),
        .i_baseline (r_baseline),
        .o_climb    (climb)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_move) begin
            r_out_pressure <= r_prev;
        end
    end

    assign o_result_ch.valid             = r_out_valid;
    assign o_result_ch.smoothed_pressure = r_out_pressure;
    assign o_result_ch.climb_value       = climb;

    // Checks on the pipeline and the climb state.
    `PSCE_ASSERT_NOW(a_stall_means_full, i_clk, i_rst_n, !s1_free, r_s1_valid && r_s2_valid && r_out_valid, "input stalled with a pipeline stage empty")
    `PSCE_ASSERT_NEXT(a_move_fills_out, i_clk, i_rst_n, i_rst_n && s2_move, r_out_valid, "item lost between smoothing and result stages")
    `PSCE_ASSERT_NEXT(a_climb_holds, i_clk, i_rst_n, i_rst_n && !s2_move, $stable(climb), "climb sum changed without an item")
    `PSCE_ASSERT_NEXT(a_bypass_passes, i_clk, i_rst_n, i_rst_n && s1_move && !r_filter_en, r_prev == $past(r_s1_sample), "unfiltered sample altered")

endmodule
